// ----- rtl/psr_pkg.sv -----
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and constants of the polyphase resampler.
// ----------------------------------------------------------------------------
package psr_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int COEF_W      = 18;
	localparam int COEF_FRAC   = 16;
	localparam int STEP_W      = 9;
	localparam int NCH_W       = 2;
	localparam int ADDR_W      = 13;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [STEP_W-1:0] RST_INPUT_STEP  = 9'd160;
	localparam logic [STEP_W-1:0] RST_OUTPUT_STEP = 9'd147;
	localparam logic [NCH_W-1:0]  RST_NUM_CH      = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	localparam logic [1:0] REG_INPUT_STEP  = 2'd0;
	localparam logic [1:0] REG_OUTPUT_STEP = 2'd1;
	localparam logic [1:0] REG_NUM_CH      = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NEXT,
		ST_MAC,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

// ----- rtl/polyphase_sinc_resampler.sv -----
// ----------------------------------------------------------------------------
// polyphase_sinc_resampler
// Streaming polyphase FIR upsampler for one or two audio channels.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid/in_ready): operation selects a sample frame or a
//   coefficient write. A coefficient write gives no result.
// - A sample frame shifts into the delay lines and yields one to eight results
//   on the output channel (out_valid/out_ready); last_of_run marks the final.
// - For each result, one coefficient RAM read per tap feeds one MAC lane per
//   channel, then rounding and the output register. Positions past the eighth
//   of a frame are skipped and give no result.
// - in_ready is high only between frames; a result left waiting in the output
//   register does not block the next transaction, but the next result waits
//   until that register is taken.
// - Configuration (cfg_valid/cfg_ready) is always ready; write only when idle.
// - Reset clears delay lines, phase and row, and loads the default steps. The
//   coefficient RAM is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module polyphase_sinc_resampler import psr_pkg::*; #(
	parameter int TAPS     = 32,
	parameter int PHASES   = 256,
	parameter int CHANNELS = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic signed [SAMPLE_W-1:0] sample_ch0,
	input  logic signed [SAMPLE_W-1:0] sample_ch1,
	input  logic [ADDR_W-1:0]          coeff_address,
	input  logic signed [COEF_W-1:0]   coeff_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_ch0,
	output logic signed [SAMPLE_W-1:0] out_ch1,
	output logic                       last_of_run,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [STEP_W-1:0]          cfg_data
);

	localparam int TW     = $clog2(TAPS);
	localparam int PW     = $clog2(PHASES);
	localparam int CDEPTH = TAPS * PHASES;
	localparam int CAW    = $clog2(CDEPTH);

	state_t                    state_q, state_d;
	logic [STEP_W-1:0]         input_step_q, output_step_q;
	logic [NCH_W-1:0]          num_channels_q;
	logic [STEP_W-1:0]         eff_in, eff_out;
	logic [PW-1:0]             phase_q, row_q;
	logic [CAW-1:0]            base_q;
	logic [TW-1:0]             tap_q, tap_s1;
	logic [CNT_W-1:0]          count_q;
	logic signed [SAMPLE_W-1:0] dline_q [CHANNELS][TAPS];
	mac_ctl_t                  ctl_s0, ctl_s1;
	logic [STEP_W:0]           phase_sum;
	logic                      wrap, row_wrap;
	logic                      advance, out_free, in_acc, frame_acc, coef_we;
	logic [CAW-1:0]            raddr;
	logic [COEF_W-1:0]         coef_rd;
	logic [CHANNELS-1:0][SAMPLE_W-1:0] lane_res;
	logic [CHANNELS-1:0]       lane_done;
	logic                      ch1_on;

	assign cfg_ready = 1'b1;

	// clamp the step registers to their legal ranges
	always_comb begin
		eff_in = input_step_q;
		if (eff_in == '0) begin
			eff_in = STEP_W'(1);
		end else if (eff_in > STEP_W'(PHASES)) begin
			eff_in = STEP_W'(PHASES);
		end
		eff_out = output_step_q;
		if (eff_out == '0) begin
			eff_out = STEP_W'(1);
		end else if (eff_out > eff_in) begin
			eff_out = eff_in;
		end
	end

	assign ch1_on    = (num_channels_q >= NCH_W'(2));
	assign phase_sum = (STEP_W+1)'(phase_q) + (STEP_W+1)'(eff_out);
	assign wrap      = (phase_sum >= (STEP_W+1)'(eff_in));
	assign row_wrap  = ((STEP_W+1)'(row_q) + (STEP_W+1)'(1) >= (STEP_W+1)'(eff_in));
	assign out_free  = !out_valid || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign frame_acc = in_acc && (operation == OP_SAMPLE);
	assign coef_we   = in_acc && (operation == OP_COEF)
		&& (32'(coeff_address) < 32'(CDEPTH));

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		advance  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (frame_acc) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (count_q == CNT_W'(MAX_RESULTS)) begin
					advance = 1'b1;
					if (wrap) begin
						state_d = ST_IDLE;
					end
				end else if (out_free) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (tap_q == TW'(TAPS - 1)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (lane_done[0]) begin
					advance = 1'b1;
					state_d = wrap ? ST_IDLE : ST_NEXT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_step_q   <= RST_INPUT_STEP;
			output_step_q  <= RST_OUTPUT_STEP;
			num_channels_q <= RST_NUM_CH;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INPUT_STEP:  input_step_q   <= cfg_data;
				REG_OUTPUT_STEP: output_step_q  <= cfg_data;
				REG_NUM_CH:      num_channels_q <= cfg_data[NCH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			row_q   <= '0;
			base_q  <= '0;
			count_q <= '0;
		end else if (frame_acc) begin
			count_q <= '0;
			// drop a phase or row left over from a larger step setting
			if ((STEP_W)'(phase_q) >= eff_in) begin
				phase_q <= '0;
			end
			if ((STEP_W)'(row_q) >= eff_in) begin
				row_q  <= '0;
				base_q <= '0;
			end
		end else if (advance) begin
			phase_q <= wrap ? PW'(phase_sum - (STEP_W+1)'(eff_in)) : PW'(phase_sum);
			if (row_wrap) begin
				row_q  <= '0;
				base_q <= '0;
			end else begin
				row_q  <= row_q + PW'(1);
				base_q <= base_q + CAW'(TAPS);
			end
			if (state_q == ST_FLUSH) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q  <= '0;
			ctl_s1 <= '0;
		end else begin
			tap_q  <= (state_q == ST_MAC) ? tap_q + TW'(1) : '0;
			ctl_s1 <= ctl_s0;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1 <= tap_q;
	end

	assign ctl_s0.valid = (state_q == ST_MAC);
	assign ctl_s0.first = (tap_q == '0);
	assign ctl_s0.last  = (tap_q == TW'(TAPS - 1));
	assign raddr        = base_q + CAW'(tap_q);

	psr_ram #(
		.WIDTH (COEF_W),
		.DEPTH (CDEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (CAW'(coeff_address)),
		.wdata (coeff_value),
		.raddr (raddr),
		.rdata (coef_rd)
	);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic signed [SAMPLE_W-1:0] new_sample;
		logic signed [SAMPLE_W-1:0] lane_out;

		assign new_sample = (c == 0) ? sample_ch0 : sample_ch1;

		// index 0 holds the oldest sample
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int i = 0; i < TAPS; i++) begin
					dline_q[c][i] <= '0;
				end
			end else if (frame_acc) begin
				for (int i = 0; i < TAPS - 1; i++) begin
					dline_q[c][i] <= dline_q[c][i+1];
				end
				dline_q[c][TAPS-1] <= new_sample;
			end
		end

		psr_lane #(
			.TAPS (TAPS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl_s1),
			.sample (dline_q[c][tap_s1]),
			.coef   ($signed(coef_rd)),
			.res    (lane_out),
			.done   (lane_done[c])
		);

		assign lane_res[c] = lane_out;
	end

	psr_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (lane_done[0]),
		.last        (wrap || (count_q == CNT_W'(MAX_RESULTS - 1))),
		.ch1_on      (ch1_on),
		.lane_res    (lane_res),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_ch0     (out_ch0),
		.out_ch1     (out_ch1),
		.last_of_run (last_of_run)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RESULTS))
		else $error("result count past limit");

	a_done_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (state_q == ST_FLUSH))
		else $error("lane result outside flush");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done == {CHANNELS{lane_done[0]}})
		else $error("lanes out of step");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> !out_valid || $past(out_ready))
		else $error("result overwrote a pending transaction");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEXT) |-> (STEP_W'(phase_q) < eff_in))
		else $error("phase out of range");
`endif

endmodule

// ----- rtl/psr_ram.sv -----
// ----------------------------------------------------------------------------
// psr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psr_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/psr_lane.sv -----
// ----------------------------------------------------------------------------
// psr_lane
// One channel's multiply-accumulate lane with rounding and saturation.
// ----------------------------------------------------------------------------
module psr_lane import psr_pkg::*; #(
	parameter int TAPS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mac_ctl_t                   ctl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [COEF_W-1:0]   coef,
	output logic signed [SAMPLE_W-1:0] res,
	output logic                       done
);

	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(TAPS);
	localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W+1)'(2**(SAMPLE_W-1) - 1);
	localparam logic signed [ACC_W:0] SAT_MIN = -((ACC_W+1)'(2**(SAMPLE_W-1)));
	localparam logic signed [ACC_W:0] RND     = (ACC_W+1)'(2**(COEF_FRAC-1));

	mac_ctl_t                   ctl_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       done_s3;
	logic signed [ACC_W:0]      rnd;
	logic signed [ACC_W:0]      shifted;
	logic signed [SAMPLE_W-1:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			done_s3 <= 1'b0;
			done    <= 1'b0;
		end else begin
			ctl_s2  <= ctl;
			done_s3 <= ctl_s2.valid && ctl_s2.last;
			done    <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= sample * coef;
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		if (done_s3) begin
			res <= sat;
		end
	end

	// round half up, floor shift, clip to the sample range
	always_comb begin
		rnd     = $signed({acc_q[ACC_W-1], acc_q}) + RND;
		shifted = rnd >>> COEF_FRAC;
		if (shifted > SAT_MAX) begin
			sat = SAT_MAX[SAMPLE_W-1:0];
		end else if (shifted < SAT_MIN) begin
			sat = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			sat = shifted[SAMPLE_W-1:0];
		end
	end

endmodule

// ----- rtl/psr_merge.sv -----
// ----------------------------------------------------------------------------
// psr_merge
// Collects the lane results into the output register and drives the output
// channel.
// ----------------------------------------------------------------------------
module psr_merge import psr_pkg::*; #(
	parameter int CHANNELS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                last,
	input  logic                                ch1_on,
	input  logic [CHANNELS-1:0][SAMPLE_W-1:0]   lane_res,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [SAMPLE_W-1:0]          out_ch0,
	output logic signed [SAMPLE_W-1:0]          out_ch1,
	output logic                                last_of_run
);

	logic [SAMPLE_W-1:0] ch1_val;

	assign ch1_val = (CHANNELS > 1 && ch1_on) ? lane_res[CHANNELS-1] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_ch0     <= $signed(lane_res[0]);
			out_ch1     <= $signed(ch1_val);
			last_of_run <= last;
		end
	end

endmodule
